// ----- rtl/grw_pkg.sv -----
// ----------------------------------------------------------------------------
// grw_pkg
// Types, constants and the sine table shared by the grid ray wall finder.
// ----------------------------------------------------------------------------
package grw_pkg;

    localparam int MAP_BITS   = 6;
    localparam int CELL_AW    = 2 * MAP_BITS;
    localparam int MAP_CELLS  = 1 << CELL_AW;
    localparam int ANGLE_BITS = 12;
    localparam int PHASE_BITS = 16;
    localparam int TRIG_BITS  = 15;
    localparam int DELTA_BITS = 31;
    localparam int DIST_BITS  = 40;
    localparam int CS_BITS    = 11;
    localparam int STEP_BITS  = 8;
    localparam int DPX_BITS   = 24;
    localparam int WPX_BITS   = 16;
    localparam int PROD_BITS  = DIST_BITS + CS_BITS;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef enum logic [0:0] {
        REG_CELL_PX   = 1'b0,
        REG_MAX_STEPS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                  kind;
        logic [MAP_BITS-1:0]   cell_x;
        logic [MAP_BITS-1:0]   cell_y;
        logic                  cell_is_wall;
        logic [15:0]           start_x;
        logic [15:0]           start_y;
        logic [ANGLE_BITS-1:0] heading;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DELTA_BITS-1:0] quotient;
    } div_stat_t;

    typedef struct packed {
        logic                hit;
        logic                side;
        logic [MAP_BITS-1:0] hit_cell_x;
        logic [MAP_BITS-1:0] hit_cell_y;
        logic [DPX_BITS-1:0] distance_px;
        logic [WPX_BITS-1:0] wall_px_x;
        logic [WPX_BITS-1:0] wall_px_y;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRIG,
        ST_DIV,
        ST_FIRST,
        ST_STEP,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RESULT
    } back_state_t;

    // quarter-wave sine, Q1.14, 17 points
    function automatic logic [TRIG_BITS-1:0] quarter_entry(input logic [4:0] idx);
        logic [TRIG_BITS-1:0] v;
        unique case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            5'd16:   v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // magnitude of sine at a 16-bit phase; sign is phase[15]
    function automatic logic [TRIG_BITS-1:0] sine_mag(input logic [PHASE_BITS-1:0] phase);
        logic [TRIG_BITS-1:0] r;
        logic [4:0]           idx;
        logic [9:0]           f;
        logic [TRIG_BITS-1:0] base;
        logic [TRIG_BITS-1:0] nxt;
        logic [10:0]          diff;
        logic [20:0]          prod;
        logic [TRIG_BITS-1:0] res;
        r    = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
        idx  = r[14:10];
        f    = r[9:0];
        base = quarter_entry(idx);
        nxt  = quarter_entry(idx + 5'd1);
        diff = 11'(nxt - base);
        prod = 21'(diff * f) + 21'd512;
        if (idx == 5'd16)
        begin
            res = 15'd16384;
        end
        else
        begin
            res = base + 15'(prod[20:10]);
        end
        return res;
    endfunction

endpackage

// ----- rtl/grw_ram.sv -----
// ----------------------------------------------------------------------------
// grw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/grw_front.sv -----
// ----------------------------------------------------------------------------
// grw_front
// Input side: accepts items into a two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
module grw_front
    import grw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  clearing,
    input  logic  pop,
    output head_t head
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;

    assign in_stall   = clearing || (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/grw_divider.sv -----
// ----------------------------------------------------------------------------
// grw_divider
// Restoring divider for 2^30 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grw_divider
    import grw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TRIG_BITS-1:0] divisor,
    output div_stat_t            stat
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [4:0]            cnt_reg;
    logic [4:0]            cnt_next;
    logic [TRIG_BITS-1:0]  rem_reg;
    logic [TRIG_BITS-1:0]  rem_next;
    logic [TRIG_BITS-1:0]  div_reg;
    logic [TRIG_BITS-1:0]  div_next;
    logic [DELTA_BITS-1:0] quo_reg;
    logic [DELTA_BITS-1:0] quo_next;
    logic [TRIG_BITS:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        // dividend has a single one at bit 30
        trial     = {rem_reg, (cnt_reg == 5'd30)};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd30;
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = TRIG_BITS'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[DELTA_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = TRIG_BITS'(trial);
                quo_next = {quo_reg[DELTA_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ----- rtl/grw_back.sv -----
// ----------------------------------------------------------------------------
// grw_back
// Back end: map clearing and writes, ray setup, the DDA grid walk and result scaling.
// ----------------------------------------------------------------------------
module grw_back
    import grw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  head_t                 head,
    output logic                  pop,
    output logic                  clearing,
    input  logic [CS_BITS-1:0]    cell_px,
    input  logic [STEP_BITS-1:0]  max_steps,
    output logic                  div_start,
    output logic [TRIG_BITS-1:0]  div_divisor,
    input  div_stat_t             div_stat,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [CELL_AW-1:0]    clr_reg;
    logic [CELL_AW-1:0]    clr_next;
    item_t                 cur_reg;
    item_t                 cur_next;
    logic                  axis_reg;
    logic                  axis_next;
    logic [DELTA_BITS-1:0] dx_reg;
    logic [DELTA_BITS-1:0] dx_next;
    logic [DELTA_BITS-1:0] dy_reg;
    logic [DELTA_BITS-1:0] dy_next;
    logic [DIST_BITS-1:0]  sx_reg;
    logic [DIST_BITS-1:0]  sx_next;
    logic [DIST_BITS-1:0]  sy_reg;
    logic [DIST_BITS-1:0]  sy_next;
    logic                  negx_reg;
    logic                  negx_next;
    logic                  negy_reg;
    logic                  negy_next;
    logic                  infx_reg;
    logic                  infx_next;
    logic                  infy_reg;
    logic                  infy_next;
    logic [MAP_BITS-1:0]   mx_reg;
    logic [MAP_BITS-1:0]   mx_next;
    logic [MAP_BITS-1:0]   my_reg;
    logic [MAP_BITS-1:0]   my_next;
    logic [STEP_BITS-1:0]  n_reg;
    logic [STEP_BITS-1:0]  n_next;
    logic [DIST_BITS-1:0]  dist_reg;
    logic [DIST_BITS-1:0]  dist_next;
    logic                  side_reg;
    logic                  side_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [PROD_BITS-1:0]  prod_next;

    logic                  ram_we;
    logic [CELL_AW-1:0]    ram_waddr;
    logic                  ram_wdata;
    logic                  ram_re;
    logic [CELL_AW-1:0]    ram_raddr;
    logic                  ram_rdata;

    logic [PHASE_BITS-1:0] phase;
    logic [TRIG_BITS-1:0]  mag;
    logic                  cur_neg;
    logic [9:0]            frac;
    logic [10:0]           span;
    logic [DELTA_BITS-1:0] cur_delta;
    logic [41:0]           first_prod;
    logic                  gox;
    logic                  leaves;
    logic [MAP_BITS-1:0]   nx;
    logic [MAP_BITS-1:0]   ny;
    logic [DPX_BITS-1:0]   dpx;

    grw_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ray setup terms for the axis in work
    assign phase      = {cur_reg.heading, 4'b0000} + (axis_reg ? 16'h0000 : 16'h4000);
    assign mag        = sine_mag(phase);
    assign cur_neg    = axis_reg ? negy_reg : negx_reg;
    assign frac       = axis_reg ? cur_reg.start_y[9:0] : cur_reg.start_x[9:0];
    assign span       = cur_neg ? {1'b0, frac} : (11'd1024 - {1'b0, frac});
    assign cur_delta  = axis_reg ? dy_reg : dx_reg;
    assign first_prod = 42'(span * cur_delta);

    // next DDA step; ties go to the row axis
    always_comb
    begin
        gox = !infx_reg && (infy_reg || (sx_reg < sy_reg));
        nx  = mx_reg;
        ny  = my_reg;
        if (gox)
        begin
            leaves = negx_reg ? (mx_reg == '0) : (mx_reg == '1);
            nx     = negx_reg ? (mx_reg - 6'd1) : (mx_reg + 6'd1);
        end
        else
        begin
            leaves = negy_reg ? (my_reg == '0) : (my_reg == '1);
            ny     = negy_reg ? (my_reg - 6'd1) : (my_reg + 6'd1);
        end
    end

    assign dpx = (|prod_reg[PROD_BITS-1:12+DPX_BITS]) ? '1 : prod_reg[12+DPX_BITS-1:12];

    assign res.hit         = hit_reg;
    assign res.side        = side_reg;
    assign res.hit_cell_x  = mx_reg;
    assign res.hit_cell_y  = my_reg;
    assign res.distance_px = dpx;
    assign res.wall_px_x   = WPX_BITS'(mx_reg * cell_px);
    assign res.wall_px_y   = WPX_BITS'(my_reg * cell_px);

    assign clearing    = (state_reg == ST_CLEAR);
    assign div_divisor = mag;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        axis_next  = axis_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        infx_next  = infx_reg;
        infy_next  = infy_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        n_next     = n_reg;
        dist_next  = dist_reg;
        side_next  = side_reg;
        hit_next   = hit_reg;
        prod_next  = prod_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = {ny, nx};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + CELL_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == KIND_WRITE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = {head.item.cell_y, head.item.cell_x};
                        ram_wdata = head.item.cell_is_wall;
                    end
                    else
                    begin
                        cur_next   = head.item;
                        axis_next  = 1'b0;
                        n_next     = '0;
                        hit_next   = 1'b0;
                        side_next  = 1'b0;
                        dist_next  = '0;
                        mx_next    = head.item.start_x[15:10];
                        my_next    = head.item.start_y[15:10];
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG:
            begin
                if (axis_reg)
                begin
                    negy_next = phase[15];
                    infy_next = (mag == '0);
                end
                else
                begin
                    negx_next = phase[15];
                    infx_next = (mag == '0);
                end
                if (mag == '0)
                begin
                    // zero component: axis never stepped
                    axis_next  = 1'b1;
                    state_next = axis_reg ? ST_STEP : ST_TRIG;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (axis_reg)
                    begin
                        dy_next = div_stat.quotient;
                    end
                    else
                    begin
                        dx_next = div_stat.quotient;
                    end
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (axis_reg)
                begin
                    sy_next = DIST_BITS'(first_prod[41:10]);
                end
                else
                begin
                    sx_next = DIST_BITS'(first_prod[41:10]);
                end
                axis_next  = 1'b1;
                state_next = axis_reg ? ST_STEP : ST_TRIG;
            end
            ST_STEP:
            begin
                if (n_reg >= max_steps)
                begin
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    n_next = n_reg + 8'd1;
                    if (gox)
                    begin
                        dist_next = sx_reg;
                        sx_next   = sx_reg + DIST_BITS'(dx_reg);
                        side_next = 1'b0;
                    end
                    else
                    begin
                        dist_next = sy_reg;
                        sy_next   = sy_reg + DIST_BITS'(dy_reg);
                        side_next = 1'b1;
                    end
                    if (leaves)
                    begin
                        state_next = ST_MUL_LO;
                    end
                    else
                    begin
                        mx_next    = nx;
                        my_next    = ny;
                        ram_re     = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (ram_rdata)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_MUL_LO:
            begin
                prod_next  = PROD_BITS'(dist_reg[19:0] * cell_px);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                prod_next  = prod_reg +
                             {(PROD_BITS-20)'(dist_reg[DIST_BITS-1:20] * cell_px), 20'd0};
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        axis_reg <= axis_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        infx_reg <= infx_next;
        infy_reg <= infy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        n_reg    <= n_next;
        dist_reg <= dist_next;
        side_reg <= side_next;
        hit_reg  <= hit_next;
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/grid_ray_wall_finder_core.sv -----
// ----------------------------------------------------------------------------
// grid_ray_wall_finder_core
// DDA ray caster over a 64 x 64 map of wall bits, with an APB register port.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | kind, cell, wall bit, start pos, heading
//   out     | out_valid/ out_stall | hit, side, cell, distance, wall pixels
//   cfg     | APB psel/penable     | cell pixels (0x0), max_steps (0x4)
//
// In the back end a cast sets up each axis with one divide (none for a zero
// component), then walks the grid with one map read per step inside the map,
// then scales the distance and delivers the result.
// After reset a clearing pass zeroes all 4096 map cells; in_stall is high.
// A two-item queue sits between input and back end; the output register
// holds a result while out_stall is high.
// ----------------------------------------------------------------------------
module grid_ray_wall_finder_core
    import grw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic        cell_is_wall,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [11:0] heading,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        side,
    output logic [5:0]  hit_cell_x,
    output logic [5:0]  hit_cell_y,
    output logic [23:0] distance_px,
    output logic [15:0] wall_px_x,
    output logic [15:0] wall_px_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    item_t                in_item;
    head_t                head;
    logic                 pop;
    logic                 clearing;
    logic                 div_start;
    logic [TRIG_BITS-1:0] div_divisor;
    div_stat_t            div_stat;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    logic                 cfg_we;

    logic [CS_BITS-1:0]   cell_px_reg;
    logic [CS_BITS-1:0]   cell_px_next;
    logic [STEP_BITS-1:0] max_steps_reg;
    logic [STEP_BITS-1:0] max_steps_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    result_t              out_next;

    assign in_item.kind         = kind;
    assign in_item.cell_x       = cell_x;
    assign in_item.cell_y       = cell_y;
    assign in_item.cell_is_wall = cell_is_wall;
    assign in_item.start_x      = start_x;
    assign in_item.start_y      = start_y;
    assign in_item.heading      = heading;

    grw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .clearing (clearing),
        .pop      (pop),
        .head     (head)
    );

    grw_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .stat    (div_stat)
    );

    grw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .clearing    (clearing),
        .cell_px     (cell_px_reg),
        .max_steps   (max_steps_reg),
        .div_start   (div_start),
        .div_divisor (div_divisor),
        .div_stat    (div_stat),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        cell_px_next   = cell_px_reg;
        max_steps_next = max_steps_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_CELL_PX:   cell_px_next   = pwdata[CS_BITS-1:0];
                REG_MAX_STEPS: max_steps_next = pwdata[STEP_BITS-1:0];
                default:       cell_px_next   = cell_px_reg;
            endcase
        end
        prdata = (reg_idx_t'(paddr[2]) == REG_CELL_PX) ?
                 {{(32-CS_BITS){1'b0}}, cell_px_reg} :
                 {{(32-STEP_BITS){1'b0}}, max_steps_reg};
    end

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_px_reg   <= 11'd64;
            max_steps_reg <= 8'd128;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cell_px_reg   <= cell_px_next;
            max_steps_reg <= max_steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_reg.hit;
    assign side        = out_reg.side;
    assign hit_cell_x  = out_reg.hit_cell_x;
    assign hit_cell_y  = out_reg.hit_cell_y;
    assign distance_px = out_reg.distance_px;
    assign wall_px_x   = out_reg.wall_px_x;
    assign wall_px_y   = out_reg.wall_px_y;

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("item accepted during map clear");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> !div_stat.done)
        else $error("divider done held longer than one cycle");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !head.valid) |=> head.valid)
        else $error("accepted item missing from queue");

endmodule

// ----- bench/grw_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grw_result_checker
// Watches the item, result and register channels of the ray wall finder,
// keeps its own map and register copies, predicts each cast result and
// compares it as a whole in arrival order.
// ----------------------------------------------------------------------------
module grw_result_checker
    import grw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic        cell_is_wall,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [11:0] heading,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        hit,
    input  logic        side,
    input  logic [5:0]  hit_cell_x,
    input  logic [5:0]  hit_cell_y,
    input  logic [23:0] distance_px,
    input  logic [15:0] wall_px_x,
    input  logic [15:0] wall_px_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fails,
    output int          pending
);

    localparam int SINE_PTS[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                    12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

    bit        wall_map[MAP_CELLS];
    bit [10:0] px_per_cell;
    bit [7:0]  step_limit;
    result_t   cast_results[$];

    function automatic longint quarter_wave(longint r);
        longint i;
        longint f;
        i = r >> 10;
        f = r & 1023;
        if (i >= 16)
        begin
            return 16384;
        end
        return SINE_PTS[i] + (((SINE_PTS[i+1] - SINE_PTS[i]) * f + 512) >> 10);
    endfunction

    function automatic longint sine_at(longint p);
        longint q;
        longint r;
        longint mag;
        p   = p & 16'hFFFF;
        q   = p >> 14;
        r   = p & 16'h3FFF;
        mag = q[0] ? quarter_wave(16384 - r) : quarter_wave(r);
        return (q >= 2) ? -mag : mag;
    endfunction

    // per-axis step length and first crossing, Q.16 cells; zero component never steps
    function automatic void axis_walk(input longint d, input longint frac, output longint delta,
                                      output longint first, output int dir, output bit inf);
        longint mag;
        inf   = (d == 0);
        delta = 0;
        first = 0;
        dir   = 1;
        if (!inf)
        begin
            mag   = (d < 0) ? -d : d;
            delta = (longint'(1) << 30) / mag;
            first = (((d < 0) ? frac : 1024 - frac) * delta) >> 10;
            dir   = (d > 0) ? 1 : -1;
        end
    endfunction

    function automatic result_t cast_ray(bit [15:0] pos_x, bit [15:0] pos_y, bit [11:0] ang);
        result_t res;
        longint  phase;
        longint  dlx, dly, sx, sy, walk_len, dpx;
        int      stx, sty, mx, my, nx, ny, n;
        bit      infx, infy, found, crossed_row;
        phase = longint'(ang) << 4;
        axis_walk(sine_at(phase + 16384), pos_x & 1023, dlx, sx, stx, infx);
        axis_walk(sine_at(phase), pos_y & 1023, dly, sy, sty, infy);
        mx = pos_x >> 10;
        my = pos_y >> 10;
        n = 0;
        walk_len = 0;
        found = 0;
        crossed_row = 0;
        // the start cell is never tested; stop at a wall, the edge or the limit
        while (n < step_limit && !found)
        begin
            nx = mx;
            ny = my;
            if (!infx && (infy || sx < sy))
            begin
                walk_len = sx;
                sx += dlx;
                nx += stx;
                crossed_row = 0;
            end
            else
            begin
                walk_len = sy;
                sy += dly;
                ny += sty;
                crossed_row = 1;
            end
            n++;
            if (nx < 0 || ny < 0 || nx >= 64 || ny >= 64)
            begin
                break;
            end
            mx = nx;
            my = ny;
            found = wall_map[my * 64 + mx];
        end
        dpx = (walk_len * px_per_cell) >> 12;
        if (dpx > 24'hFFFFFF)
        begin
            dpx = 24'hFFFFFF;
        end
        res.hit         = found;
        res.side        = crossed_row;
        res.hit_cell_x  = mx[5:0];
        res.hit_cell_y  = my[5:0];
        res.distance_px = dpx[23:0];
        res.wall_px_x   = 16'(mx * px_per_cell);
        res.wall_px_y   = 16'(my * px_per_cell);
        return res;
    endfunction

    assign pending = cast_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            foreach (wall_map[i])
            begin
                wall_map[i] = 0;
            end
            px_per_cell = 11'd64;
            step_limit  = 8'd128;
            cast_results.delete();
            fails = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_CELL_PX)
                begin
                    px_per_cell = pwdata[10:0];
                end
                else
                begin
                    step_limit = pwdata[7:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_WRITE)
                begin
                    wall_map[{cell_y, cell_x}] = cell_is_wall;
                end
                else
                begin
                    cast_results.push_back(cast_ray(start_x, start_y, heading));
                end
            end
            if (out_valid && !out_stall)
            begin
                got = '{hit, side, hit_cell_x, hit_cell_y, distance_px, wall_px_x, wall_px_y};
                if (cast_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("unexpected result %p", got);
                    end
                end
                else
                begin
                    want = cast_results.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch: expected %p, got %p", want, got);
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- bench/tb_grid_ray_wall_finder_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_ray_wall_finder_core
// Drives map writes and ray casts under random idling and stalls through
// several register settings; a checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_grid_ray_wall_finder_core;
    import grw_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 800;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        kind = 0;
    logic [5:0]  cell_x = 0;
    logic [5:0]  cell_y = 0;
    logic        cell_is_wall = 0;
    logic [15:0] start_x = 0;
    logic [15:0] start_y = 0;
    logic [11:0] heading = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        hit;
    logic        side;
    logic [5:0]  hit_cell_x;
    logic [5:0]  hit_cell_y;
    logic [23:0] distance_px;
    logic [15:0] wall_px_x;
    logic [15:0] wall_px_y;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          pending;
    int          cycles = 0;
    bit          calm = 0;
    int          wall_pct = 20;

    grid_ray_wall_finder_core dut (.*);

    grw_result_checker checker_i (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= !calm && ($urandom_range(99) < 38);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_grid_ray_wall_finder_core NOT OK");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
    endtask

    // hold the item until the block takes it; valid stays up for a following item
    task automatic send(bit k, bit [5:0] x, bit [5:0] y, bit w, bit [15:0] pxx, bit [15:0] pyy,
                        bit [11:0] ang);
        while (!calm && $urandom_range(99) < 38)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid     <= 1;
        kind         <= k;
        cell_x       <= x;
        cell_y       <= y;
        cell_is_wall <= w;
        start_x      <= pxx;
        start_y      <= pyy;
        heading      <= ang;
        do
        begin
            @(negedge clk);
        end
        while (in_stall);
        @(posedge clk);
    endtask

    task automatic cast(bit [15:0] pxx, bit [15:0] pyy, bit [11:0] ang);
        send(KIND_CAST, 6'($urandom), 6'($urandom), 1'($urandom), pxx, pyy, ang);
    endtask

    task automatic put_cell(bit [5:0] x, bit [5:0] y, bit w);
        send(KIND_WRITE, x, y, w, 16'($urandom), 16'($urandom), 12'($urandom));
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_items(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 35)
            begin
                put_cell(6'($urandom), 6'($urandom), $urandom_range(99) < wall_pct);
            end
            else if ($urandom_range(9) == 0)
            begin
                // axis-aligned and diagonal angles with cell-centered positions
                cast({6'($urandom_range(63)), 10'd512}, {6'($urandom_range(63)), 10'd512},
                     12'($urandom_range(7) * 512));
            end
            else
            begin
                cast(16'($urandom), 16'($urandom), 12'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);

        // directed: corners, axis directions, edges, walls next to the start
        put_cell(0, 0, 1);
        put_cell(63, 63, 1);
        put_cell(6'h2A, 6'h15, 1);
        put_cell(6'h15, 6'h2A, 1);
        put_cell(11, 10, 1);
        cast(16'h0000, 16'h0000, 12'd0);
        cast(16'hFFFF, 16'hFFFF, 12'd4095);
        cast({6'd10, 10'd512}, {6'd10, 10'd512}, 12'd0);
        cast({6'd10, 10'd512}, {6'd10, 10'd512}, 12'd1024);
        cast({6'd10, 10'd512}, {6'd10, 10'd512}, 12'd2048);
        cast({6'd10, 10'd512}, {6'd10, 10'd512}, 12'd3072);
        cast({6'd10, 10'd0}, {6'd10, 10'd0}, 12'd512);
        cast({6'd1, 10'd1023}, {6'd1, 10'd1}, 12'd2560);
        cast({6'd32, 10'd0}, {6'd32, 10'd0}, 12'd1);
        cast(16'hFFFF, 16'h0000, 12'd2047);
        cast(16'h0000, 16'hFFFF, 12'd3584);
        put_cell(11, 10, 0);
        cast({6'd10, 10'd512}, {6'd10, 10'd512}, 12'd0);
        cast(16'h5555, 16'hAAAA, 12'hAAA);
        cast(16'hAAAA, 16'h5555, 12'h555);
        drain();

        write_reg(REG_CELL_PX, 1);
        write_reg(REG_MAX_STEPS, 255);
        random_items(250);
        drain();

        write_reg(REG_CELL_PX, 1024);
        write_reg(REG_MAX_STEPS, 1);
        cast({6'd5, 10'd512}, {6'd5, 10'd512}, 12'd100);
        cast(16'hFFFF, 16'hFFFF, 12'd0);
        random_items(150);
        // let every expected result arrive before sending more
        in_valid <= 0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        calm = 1;
        wall_pct = 5;
        random_items(200);
        calm = 0;
        drain();

        write_reg(REG_CELL_PX, 1024);
        write_reg(REG_MAX_STEPS, 255);
        random_items(250);
        drain();

        write_reg(REG_CELL_PX, 37);
        write_reg(REG_MAX_STEPS, 20);
        wall_pct = 60;
        random_items(250);
        drain();

        write_reg(REG_CELL_PX, 200);
        write_reg(REG_MAX_STEPS, 64);
        wall_pct = 20;
        random_items(230);
        drain();

        if (fails == 0)
        begin
            $display("tb_grid_ray_wall_finder_core OK");
        end
        else
        begin
            $display("tb_grid_ray_wall_finder_core NOT OK");
        end
        $finish;
    end

endmodule

// ----- grid_ray_wall_finder_core.f -----
rtl/grw_pkg.sv
rtl/grw_ram.sv
rtl/grw_front.sv
rtl/grw_divider.sv
rtl/grw_back.sv
rtl/grid_ray_wall_finder_core.sv
bench/grw_result_checker.sv
bench/tb_grid_ray_wall_finder_core.sv
